// File: design/sfa_pkg.sv
package sfa_pkg;

   localparam int ADDR_W         = 48;
   localparam int SIZE_W         = 19;
   localparam int GRANULE_LOG2   = 4;
   localparam int GRANULE_BYTES  = 1 << GRANULE_LOG2;
   localparam int SL_LOG2        = 2;
   localparam int MIN_CLASS_LOG2 = 4;
   localparam int CLASS_COUNT    = 64;
   localparam int CLASS_W        = 6;
   localparam int POOL_LOG2      = 18;
   localparam int IDX_W          = POOL_LOG2 - GRANULE_LOG2;
   localparam int HDR_DEPTH      = 1 << IDX_W;
   localparam int LINK_W         = IDX_W + 1;

   localparam logic [LINK_W-1:0] LINK_NULL = '1;
   localparam logic [SIZE_W-1:0] POOL_RESET = SIZE_W'(262144);

   typedef logic [1:0] status_type;
   localparam status_type ST_GRANTED   = 2'd0;
   localparam status_type ST_EXHAUSTED = 2'd1;
   localparam status_type ST_FREED     = 2'd2;
   localparam status_type ST_REJECTED  = 2'd3;

   localparam logic CSR_BASE = 1'b0;
   localparam logic CSR_POOL = 1'b1;

   typedef struct packed {
      logic       capture;
      logic       decode;
      logic       free_read;
      logic       push_free;
      logic       find;
      logic       pop;
      logic       repair;
      logic       unlink;
      logic       rem_read;
      logic       push_rem;
      logic       finish;
      status_type code;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic reject;
      logic none;
      logic head_bad;
      logic split;
      logic rsp_busy;
   } stat_type;

   function automatic logic [4:0] top_bit(input logic [19:0] v);
      logic [4:0] n;
      n = '0;
      for (int i = 1; i < 20; i++) begin
         if (v[i]) n = 5'(i);
      end
      return n;
   endfunction

   function automatic logic [6:0] class_of(input logic [19:0] v);
      logic [4:0]  fl;
      logic [19:0] sh;
      logic [6:0]  cls;
      fl  = top_bit(v);
      sh  = v >> (fl - 5'(SL_LOG2));
      cls = '0;
      if (fl >= 5'(MIN_CLASS_LOG2)) begin
         cls = {2'b00, fl - 5'(MIN_CLASS_LOG2)} << SL_LOG2;
         cls = cls + 7'(sh[SL_LOG2-1:0]);
      end
      return cls;
   endfunction

   function automatic logic [CLASS_W-1:0] clamp_class(input logic [6:0] c);
      return (c >= 7'(CLASS_COUNT)) ? CLASS_W'(CLASS_COUNT - 1) : c[CLASS_W-1:0];
   endfunction

endpackage

// File: design/sfa_ctrl.sv
module sfa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  sfa_pkg::stat_type stat,
   output sfa_pkg::cmd_type  cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CALC = 4'd1;
   localparam logic [3:0] S_FRD  = 4'd2;
   localparam logic [3:0] S_FWR  = 4'd3;
   localparam logic [3:0] S_FIND = 4'd4;
   localparam logic [3:0] S_HEAD = 4'd5;
   localparam logic [3:0] S_LINK = 4'd6;
   localparam logic [3:0] S_RRD  = 4'd7;
   localparam logic [3:0] S_RWR  = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   logic [3:0]          state_ff, state_in;
   sfa_pkg::status_type code_ff, code_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd      = '0;
      cmd.code = code_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_CALC;
            end
         end
         S_CALC: begin
            cmd.decode = 1'b1;
            if (stat.is_free) begin
               if (stat.reject) begin
                  code_in  = sfa_pkg::ST_REJECTED;
                  state_in = S_DONE;
               end else begin
                  state_in = S_FRD;
               end
            end else begin
               state_in = S_FIND;
            end
         end
         S_FRD: begin
            cmd.free_read = 1'b1;
            state_in      = S_FWR;
         end
         S_FWR: begin
            cmd.push_free = 1'b1;
            code_in       = sfa_pkg::ST_FREED;
            state_in      = S_DONE;
         end
         S_FIND: begin
            cmd.find = 1'b1;
            state_in = S_HEAD;
         end
         S_HEAD: begin
            code_in  = sfa_pkg::ST_EXHAUSTED;
            state_in = S_DONE;
            if (!stat.none) begin
               if (stat.head_bad) begin
                  cmd.repair = 1'b1;
               end else begin
                  cmd.pop  = 1'b1;
                  state_in = S_LINK;
               end
            end
         end
         S_LINK: begin
            cmd.unlink = 1'b1;
            code_in    = sfa_pkg::ST_GRANTED;
            state_in   = stat.split ? S_RRD : S_DONE;
         end
         S_RRD: begin
            cmd.rem_read = 1'b1;
            state_in     = S_RWR;
         end
         S_RWR: begin
            cmd.push_rem = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= sfa_pkg::ST_GRANTED;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

// File: design/sfa_datapath.sv
module sfa_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [sfa_pkg::ADDR_W-1:0]  csr_wdata,
   input  logic                        req_func,
   input  logic [sfa_pkg::SIZE_W-1:0]  req_size,
   input  logic [sfa_pkg::ADDR_W-1:0]  req_addr,
   input  logic                        rsp_tready,
   output logic                        rsp_tvalid,
   output sfa_pkg::status_type         rsp_status,
   output logic [sfa_pkg::ADDR_W-1:0]  rsp_addr,
   output logic [sfa_pkg::SIZE_W-1:0]  rsp_size,
   input  sfa_pkg::cmd_type            cmd,
   output sfa_pkg::stat_type           stat
);

   localparam int AW = sfa_pkg::ADDR_W;
   localparam int SW = sfa_pkg::SIZE_W;
   localparam int CW = sfa_pkg::CLASS_W;
   localparam int IW = sfa_pkg::IDX_W;
   localparam int LW = sfa_pkg::LINK_W;
   localparam int GL = sfa_pkg::GRANULE_LOG2;

   logic [AW-1:0] base_ff;
   logic [SW-1:0] pool_ff;

   logic          func_ff;
   logic [SW-1:0] size_ff;
   logic [AW-1:0] addr_ff;

   logic [19:0]   aligned_ff;
   logic [6:0]    ideal_ff;
   logic [CW-1:0] fcls_ff;
   logic [IW-1:0] idx_ff;
   logic [CW-1:0] c_ff;
   logic          none_ff;
   logic [IW-1:0] blk_ff;
   logic [IW-1:0] rem_idx_ff;
   logic [SW-1:0] rem_size_ff;
   logic [SW-1:0] gsize_ff;
   logic [CW-1:0] rcls_ff;
   logic [63:0]   bitmap_ff;

   logic [LW-1:0] head_mem [sfa_pkg::CLASS_COUNT];
   logic [63:0]   head_vld_ff;
   logic [LW-1:0] head_rd_ff;
   logic          head_vq_ff;
   logic [SW-1:0] hsize_mem [sfa_pkg::HDR_DEPTH];
   logic [LW-1:0] hnext_mem [sfa_pkg::HDR_DEPTH];
   logic [SW-1:0] hsz_q_ff;
   logic [LW-1:0] hnx_q_ff;

   logic          rsp_valid_ff;
   sfa_pkg::status_type rsp_code_ff;
   logic [AW-1:0] rsp_addr_ff;
   logic [SW-1:0] rsp_size_ff;

   // Decode of the captured request.
   logic [SW-1:0] size_nz;
   logic [19:0]   size_up, aligned, target;
   logic [4:0]    afl;
   logic [AW-1:0] off;
   logic          reject;
   always_comb begin
      size_nz = (size_ff == '0) ? SW'(1) : size_ff;
      size_up = {1'b0, size_nz} + 20'(sfa_pkg::GRANULE_BYTES - 1);
      aligned = {size_up[19:GL], GL'(0)};
      afl     = sfa_pkg::top_bit(aligned);
      target  = aligned + ((20'd1 << (afl - 5'(sfa_pkg::SL_LOG2))) - 20'd1);
      off     = addr_ff - base_ff;
      reject  = (addr_ff < base_ff) || (size_ff < SW'(sfa_pkg::GRANULE_BYTES)) ||
                (off >= AW'(pool_ff)) || (off[GL-1:0] != '0) ||
                (off[AW-1:sfa_pkg::POOL_LOG2] != '0);
   end

   // Lowest non-empty class at or above the ideal class.
   logic [63:0]   avail;
   logic [CW-1:0] pick;
   always_comb begin
      avail = ideal_ff[6] ? 64'd0 : (bitmap_ff & ({64{1'b1}} << ideal_ff[5:0]));
      pick  = '0;
      for (int k = 63; k >= 0; k--) begin
         if (avail[k]) pick = CW'(k);
      end
   end

   logic [LW-1:0] head_q;
   logic [LW-1:0] nxt;
   logic [20:0]   diff;
   logic [16:0]   rem_idx;
   logic          split;
   always_comb begin
      head_q  = head_vq_ff ? head_rd_ff : sfa_pkg::LINK_NULL;
      nxt     = hnx_q_ff[LW-1] ? sfa_pkg::LINK_NULL : hnx_q_ff;
      diff    = {2'b00, hsz_q_ff} - {1'b0, aligned_ff};
      rem_idx = 17'(blk_ff) + 17'(aligned_ff[19:GL]);
      split   = ({1'b0, hsz_q_ff} >= aligned_ff) && (diff >= 21'(sfa_pkg::GRANULE_BYTES)) &&
                (rem_idx[16:IW] == '0) && ({rem_idx, GL'(0)} < 21'(pool_ff));
   end

   assign stat.is_free  = func_ff;
   assign stat.reject   = reject;
   assign stat.none     = none_ff;
   assign stat.head_bad = head_q[LW-1];
   assign stat.split    = split;
   assign stat.rsp_busy = rsp_valid_ff && !rsp_tready;

   // Head memory ports.
   logic [CW-1:0] head_ra, head_wa;
   logic          head_we;
   logic [LW-1:0] head_wd;
   always_comb begin
      head_ra = pick;
      if (cmd.free_read) head_ra = fcls_ff;
      if (cmd.rem_read) head_ra = sfa_pkg::clamp_class(sfa_pkg::class_of({1'b0, rem_size_ff}));
      head_we = cmd.repair || cmd.unlink || cmd.push_free || cmd.push_rem;
      head_wa = c_ff;
      head_wd = sfa_pkg::LINK_NULL;
      priority if (cmd.unlink) begin
         head_wd = nxt;
      end else if (cmd.push_free) begin
         head_wa = fcls_ff;
         head_wd = LW'(idx_ff);
      end else if (cmd.push_rem) begin
         head_wa = rcls_ff;
         head_wd = LW'(rem_idx_ff);
      end
   end

   // Header memory ports.
   logic          hdr_we_size, hdr_we_next;
   logic [IW-1:0] hdr_wa;
   logic [SW-1:0] hdr_wsize;
   always_comb begin
      hdr_we_size = cmd.push_free || cmd.push_rem || cmd.rem_read;
      hdr_we_next = cmd.push_free || cmd.push_rem;
      hdr_wa      = idx_ff;
      hdr_wsize   = size_ff;
      if (cmd.push_rem) begin
         hdr_wa    = rem_idx_ff;
         hdr_wsize = rem_size_ff;
      end
      if (cmd.rem_read) begin
         hdr_wa    = blk_ff;
         hdr_wsize = aligned_ff[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      head_rd_ff <= head_mem[head_ra];
      if (head_we) head_mem[head_wa] <= head_wd;
   end

   always_ff @(posedge clock) begin
      hsz_q_ff <= hsize_mem[head_q[IW-1:0]];
      hnx_q_ff <= hnext_mem[head_q[IW-1:0]];
      if (hdr_we_size) hsize_mem[hdr_wa] <= hdr_wsize;
      if (hdr_we_next) hnext_mem[hdr_wa] <= head_q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         pool_ff      <= sfa_pkg::POOL_RESET;
         bitmap_ff    <= '0;
         head_vld_ff  <= '0;
         head_vq_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == sfa_pkg::CSR_BASE) base_ff <= csr_wdata;
         if (csr_we && csr_index == sfa_pkg::CSR_POOL) pool_ff <= csr_wdata[SW-1:0];
         head_vq_ff <= head_vld_ff[head_ra];
         if (head_we) head_vld_ff[head_wa] <= 1'b1;
         if (cmd.repair) bitmap_ff[c_ff] <= 1'b0;
         if (cmd.unlink && nxt == sfa_pkg::LINK_NULL) bitmap_ff[c_ff] <= 1'b0;
         if (cmd.push_free || cmd.push_rem) bitmap_ff[head_wa] <= 1'b1;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         size_ff <= req_size;
         addr_ff <= req_addr;
      end
      if (cmd.decode) begin
         aligned_ff <= aligned;
         ideal_ff   <= sfa_pkg::class_of(target);
         fcls_ff    <= sfa_pkg::clamp_class(sfa_pkg::class_of({1'b0, size_ff}));
         idx_ff     <= off[sfa_pkg::POOL_LOG2-1:GL];
      end
      if (cmd.find) begin
         c_ff    <= pick;
         none_ff <= (avail == '0);
      end
      if (cmd.pop) blk_ff <= head_q[IW-1:0];
      if (cmd.unlink) begin
         rem_idx_ff  <= rem_idx[IW-1:0];
         rem_size_ff <= diff[SW-1:0];
         gsize_ff    <= split ? aligned_ff[SW-1:0] : hsz_q_ff;
      end
      if (cmd.rem_read) rcls_ff <= head_ra;
      if (cmd.finish) begin
         rsp_code_ff <= cmd.code;
         rsp_addr_ff <= '0;
         rsp_size_ff <= '0;
         if (cmd.code == sfa_pkg::ST_GRANTED) begin
            rsp_addr_ff <= base_ff + AW'({blk_ff, GL'(0)});
            rsp_size_ff <= gsize_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_code_ff;
   assign rsp_addr   = rsp_addr_ff;
   assign rsp_size   = rsp_size_ff;

   a_push_sets: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_free || cmd.push_rem) |=> bitmap_ff[$past(head_wa)])
      else $error("Pushed class is not marked non-empty.");

   a_unlink_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.unlink && nxt == sfa_pkg::LINK_NULL) |=> !bitmap_ff[$past(c_ff)])
      else $error("Emptied class is still marked non-empty.");

   a_find_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.find |=> (none_ff || bitmap_ff[c_ff]))
      else $error("Chosen class is not marked non-empty.");

   a_split_granted: assert property (@(posedge clock) disable iff (reset)
      (cmd.unlink && split) |=> (gsize_ff == aligned_ff[SW-1:0]))
      else $error("Split block was not trimmed to the rounded size.");

endmodule

// File: design/segregated_fit_allocator_core.sv
// Channel   Direction  Handshake                  Payload
// req_      in         req_tvalid / req_tready    tuser: func; tdata: request_size, block_address
// rsp_      out        rsp_tvalid / rsp_tready    tuser: status; tdata: granted_address, size
// csr_      in         csr_we                     csr_index, csr_wdata
//
// A free reads its class's list head and then writes the head and header; a rejected free
// skips both. An allocation reads the list head and stops there when exhausted, else goes
// on through the chain of registered reads: header link, then the head and header writes.
// A new request is taken only while the sequencer is idle, as it is again once the result is
// registered; the result register lets one finished result wait on a stalled rsp_tready
// while the next request is taken, and a second finished result waits in the sequencer.
// Reset is synchronous; the free-list heads read as empty after reset with no clearing pass.
module segregated_fit_allocator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [47:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // request_size[18:0], block_address[66:19], zero fill
   input  logic [0:0]  req_tuser,   // func[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // granted_address[47:0], granted_size[66:48], zero fill
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   sfa_pkg::cmd_type  cmd;
   sfa_pkg::stat_type stat;
   sfa_pkg::status_type rsp_status;
   logic [47:0] rsp_addr;
   logic [18:0] rsp_size;

   sfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sfa_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_func   (req_tuser[0]),
      .req_size   (req_tdata[18:0]),
      .req_addr   (req_tdata[66:19]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_status (rsp_status),
      .rsp_addr   (rsp_addr),
      .rsp_size   (rsp_size),
      .cmd        (cmd),
      .stat       (stat)
   );

   assign rsp_tdata = {5'd0, rsp_size, rsp_addr};
   assign rsp_tuser = rsp_status;

endmodule

// File: dv/sfa_checker.sv
module sfa_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [47:0] csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic [0:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          NBLK      = 16384;
   localparam logic [31:0] HEAD_NONE = 32'hFFFF_FFFF;

   typedef struct {
      sfa_pkg::status_type status;
      logic [47:0]         addr;
      logic [18:0]         size;
   } grant_type;

   grant_type   awaited[$];
   logic [47:0] pool_base;
   logic [18:0] pool_len;
   logic [63:0] class_busy;
   logic [31:0] class_head [sfa_pkg::CLASS_COUNT];
   logic [18:0] blk_size [NBLK];
   logic [31:0] blk_link [NBLK];

   function automatic int msb_of(input logic [63:0] v);
      int n;
      n = 0;
      for (int i = 1; i < 64; i++) begin
         if (v[i]) n = i;
      end
      return n;
   endfunction

   function automatic int size_class(input logic [63:0] v);
      int          fl;
      logic [63:0] sl;
      fl = msb_of(v);
      sl = (fl >= sfa_pkg::SL_LOG2) ? (v >> (fl - sfa_pkg::SL_LOG2)) :
                                      (v << (sfa_pkg::SL_LOG2 - fl));
      sl = sl ^ (64'd1 << sfa_pkg::SL_LOG2);
      if (fl < sfa_pkg::MIN_CLASS_LOG2) return 0;
      return ((fl - sfa_pkg::MIN_CLASS_LOG2) << sfa_pkg::SL_LOG2) + int'(sl);
   endfunction

   function automatic void link_block(input int idx, input logic [63:0] size);
      int c;
      c = size_class(size);
      if (c >= sfa_pkg::CLASS_COUNT) c = sfa_pkg::CLASS_COUNT - 1;
      blk_size[idx] = size[18:0];
      blk_link[idx] = class_head[c];
      class_head[c] = 32'(idx);
      class_busy[c] = 1'b1;
   endfunction

   function automatic grant_type serve(input logic func, input logic [18:0] rsize,
                                       input logic [47:0] baddr);
      grant_type   g;
      logic [63:0] size, aligned, target, avail, off, bsize, rem;
      int          fl, ideal, c;
      logic [31:0] blk, nxt;
      g.status = sfa_pkg::ST_GRANTED;
      g.addr   = '0;
      g.size   = '0;
      size     = 64'(rsize);
      if (func) begin
         off = 64'(baddr) - 64'(pool_base);
         if (baddr < pool_base || size < sfa_pkg::GRANULE_BYTES || off >= 64'(pool_len) ||
             off % sfa_pkg::GRANULE_BYTES != 0 || off / sfa_pkg::GRANULE_BYTES >= NBLK) begin
            g.status = sfa_pkg::ST_REJECTED;
         end else begin
            link_block(int'(off / sfa_pkg::GRANULE_BYTES), size);
            g.status = sfa_pkg::ST_FREED;
         end
         return g;
      end
      if (size == 0) size = 1;
      aligned = ((size + sfa_pkg::GRANULE_BYTES - 1) / sfa_pkg::GRANULE_BYTES) *
                sfa_pkg::GRANULE_BYTES;
      fl      = msb_of(aligned);
      target  = aligned;
      if (fl >= sfa_pkg::SL_LOG2) target += (64'd1 << (fl - sfa_pkg::SL_LOG2)) - 1;
      ideal = size_class(target);
      avail = (ideal >= sfa_pkg::CLASS_COUNT) ? 64'd0 : (class_busy & (~64'd0 << ideal));
      if (avail == 0) begin
         g.status = sfa_pkg::ST_EXHAUSTED;
         return g;
      end
      c = 0;
      for (int k = 63; k >= 0; k--) begin
         if (avail[k]) c = k;
      end
      blk = class_head[c];
      if (blk >= NBLK) begin
         class_busy[c] = 1'b0;
         class_head[c] = HEAD_NONE;
         g.status = sfa_pkg::ST_EXHAUSTED;
         return g;
      end
      nxt = blk_link[blk];
      if (nxt >= NBLK) nxt = HEAD_NONE;
      class_head[c] = nxt;
      if (nxt == HEAD_NONE) class_busy[c] = 1'b0;
      bsize = 64'(blk_size[blk]);
      if (bsize >= aligned && bsize - aligned >= sfa_pkg::GRANULE_BYTES) begin
         rem = 64'(blk) + aligned / sfa_pkg::GRANULE_BYTES;
         if (rem < NBLK && rem * sfa_pkg::GRANULE_BYTES < 64'(pool_len)) begin
            link_block(int'(rem), bsize - aligned);
            bsize         = aligned;
            blk_size[blk] = bsize[18:0];
         end
      end
      g.addr = pool_base + 48'(64'(blk) * sfa_pkg::GRANULE_BYTES);
      g.size = bsize[18:0];
      return g;
   endfunction

   assign pending = awaited.size();

   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         pool_base  = '0;
         pool_len   = sfa_pkg::POOL_RESET;
         class_busy = '0;
         for (int i = 0; i < sfa_pkg::CLASS_COUNT; i++) class_head[i] = HEAD_NONE;
         awaited.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected response: status %0d addr %h size %0d",
                           rsp_tuser, rsp_tdata[47:0], rsp_tdata[66:48]);
            end else begin
               want = awaited.pop_front();
               if (rsp_tuser !== want.status || rsp_tdata[47:0] !== want.addr ||
                   rsp_tdata[66:48] !== want.size || rsp_tdata[71:67] !== '0) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected status %0d addr %h size %0d, %s %0d %h %0d",
                              want.status, want.addr, want.size, "got",
                              rsp_tuser, rsp_tdata[47:0], rsp_tdata[66:48]);
               end
            end
         end
         if (req_tvalid && req_tready)
            awaited.push_back(serve(req_tuser[0], req_tdata[18:0], req_tdata[66:19]));
         if (csr_we) begin
            if (csr_index == sfa_pkg::CSR_BASE) pool_base = csr_wdata;
            else pool_len = csr_wdata[18:0];
         end
      end
   end

   initial fail_count = 0;
endmodule

// File: dv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [47:0] addr;
      logic [18:0] size;
   } block_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [47:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   int          fail_count;
   int          pending;
   int          quiet_cycles;
   int          ready_hold;
   bit          calm;
   logic [47:0] cur_base;
   block_type   held[$];

   segregated_fit_allocator_core u_top (.*);

   sfa_checker u_chk (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      logic r;
      r = 1'b1;
      if (ready_hold > 0) begin
         ready_hold--;
         r = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         ready_hold = $urandom_range(0, 5);
         r = 1'b0;
      end
      rsp_tready <= r;
   end

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready && rsp_tuser == sfa_pkg::ST_GRANTED)
         held.push_back('{rsp_tdata[47:0], rsp_tdata[66:48]});
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   task automatic send(input logic func, input logic [18:0] size, input logic [47:0] addr);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = func;
      req_tdata  = {5'b0, addr, size};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [47:0] val);
      settle();
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == sfa_pkg::CSR_BASE) cur_base = val;
   endtask

   task automatic release_all();
      block_type b;
      settle();
      while (held.size() != 0) begin
         b = held.pop_front();
         send(1'b1, b.size, b.addr);
      end
      settle();
   endtask

   task automatic churn(input int count);
      block_type b;
      int        pick;
      int        roll;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 25 && held.size() != 0) begin
            pick = $urandom_range(0, held.size() - 1);
            b    = held[pick];
            held.delete(pick);
            send(1'b1, b.size, b.addr);
         end else if (roll < 32) begin
            send(1'b1, 19'($urandom_range(0, 262144)), {16'($urandom), 32'($urandom)});
         end else if (roll < 36) begin
            send(1'b1, 19'($urandom_range(0, 4096)),
                 cur_base + 48'($urandom_range(0, 16383) * sfa_pkg::GRANULE_BYTES));
         end else if (roll < 40) begin
            send(1'b0, 19'($urandom_range(0, 262144)), {16'($urandom), 32'($urandom)});
         end else begin
            send(1'b0, 19'($urandom_range(0, 600)), {16'($urandom), 32'($urandom)});
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      calm         = 1'b0;
      ready_hold   = 0;
      quiet_cycles = 0;
      cur_base     = '0;
      csr_we       = 1'b0;
      csr_index    = sfa_pkg::CSR_BASE;
      csr_wdata    = '0;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      rsp_tready   = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send(1'b0, 19'd16, '0);
      send(1'b1, 19'd262144, 48'd0);
      send(1'b0, 19'd0, 48'hFFFF_FFFF_FFFF);
      send(1'b0, 19'd1, '0);
      send(1'b0, 19'd17, '0);
      send(1'b0, 19'd100, '0);
      send(1'b0, 19'd262144, '0);
      send(1'b1, 19'd15, 48'd4096);
      send(1'b1, 19'd64, 48'd4100);
      send(1'b1, 19'd64, 48'd262144);
      send(1'b1, 19'd64, 48'hFFFF_FFFF_FFF0);
      send(1'b1, 19'd16, 48'd8192);
      send(1'b0, 19'd8, '0);
      send(1'b1, 19'd20, 48'd8192);
      send(1'b0, 19'd24, '0);
      send(1'b1, 19'd524287, 48'd16384);
      send(1'b0, 19'd262143, '0);
      churn(110);
      release_all();

      write_reg(sfa_pkg::CSR_BASE, 48'hFFFF_FFFC_0000);
      send(1'b1, 19'd262144, 48'hFFFF_FFFC_0000);
      send(1'b1, 19'd64, 48'hFFFF_FFFB_FFF0);
      send(1'b0, 19'd262144, '0);
      churn(120);
      release_all();

      write_reg(sfa_pkg::CSR_POOL, 48'd4096);
      send(1'b1, 19'd4096, cur_base + 48'd4064);
      send(1'b0, 19'd16, '0);
      churn(120);
      release_all();

      write_reg(sfa_pkg::CSR_POOL, 48'd0);
      write_reg(sfa_pkg::CSR_BASE, 48'd0);
      churn(100);
      release_all();

      write_reg(sfa_pkg::CSR_BASE, {16'($urandom), 32'($urandom)} & ~48'hF);
      write_reg(sfa_pkg::CSR_POOL, 48'd262144);
      send(1'b1, 19'd262144, cur_base);
      churn(90);
      calm = 1'b1;
      churn(80);
      release_all();

      if (fail_count == 0 && pending == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end
endmodule
